[rtl/core/uart_command_framer_macros.svh]
// Assertion macros shared by the framer RTL.
`ifndef UART_COMMAND_FRAMER_MACROS_SVH
`define UART_COMMAND_FRAMER_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define UCF_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, checked while out of reset.
`define UCF_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/core/ucf_pkg.sv]
// Types and constants of the serial command framer.
package ucf_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TICK    = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_READ    = 2'd3
  } ucf_kind_t;

  localparam logic [7:0]  BINARY_MARK   = 8'h01;
  localparam logic [7:0]  NEWLINE_CHAR  = 8'h0A;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  // Buffer access for one word; addresses carry the widest depth.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
    logic       rd_en;
    logic [7:0] rd_addr;
  } ucf_mem_req_t;

  typedef struct packed {
    logic       message_ready;
    logic       overrun;
    logic       binary_active;
    logic [7:0] fill_count;
  } ucf_status_t;

endpackage

[rtl/core/ucf_frame_store.sv]
// Frame buffer: one write port, one registered read port.
module ucf_frame_store #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 step,
  input  ucf_pkg::ucf_mem_req_t req,
  output logic [7:0]           rd_data
);
  import ucf_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (step && req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // Non-read words return zero.
  always_ff @(posedge clk) begin
    if (step) begin
      if (req.rd_en) begin
        rd_data_r <= mem[req.rd_addr[AW-1:0]];
      end else begin
        rd_data_r <= 8'd0;
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/ucf_frame_ctrl.sv]
// Framing state: fill count, mode, pending and overrun flags, seconds timing.
module ucf_frame_ctrl #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [1:0]            kind,
  input  logic [7:0]            rx_byte,
  input  logic [6:0]            read_index,
  input  logic [15:0]           idle_timeout,
  output ucf_pkg::ucf_mem_req_t mem_req,
  output ucf_pkg::ucf_status_t  status
);
  import ucf_pkg::*;

`include "uart_command_framer_macros.svh"

  localparam logic [7:0] DEPTH_W = 8'(BUFFER_DEPTH);

  logic [7:0]  fill_r, fill_nxt;
  logic        bin_r, bin_nxt;
  logic        pend_r, pend_nxt;
  logic        ovr_r, ovr_nxt;
  logic [31:0] sec_r, sec_nxt;
  logic [31:0] last_r, last_nxt;
  logic [7:0]  len_r, len_nxt;

  logic [31:0] gap;
  logic        drop;
  logic [7:0]  fill0, fill1;
  logic        bin0, bin1;
  logic        wr;

  always_comb begin
    gap   = sec_r - last_r;
    drop  = bin_r && (gap > {16'd0, idle_timeout});
    fill0 = drop ? 8'd0 : fill_r;
    bin0  = drop ? 1'b0 : bin_r;
    bin1  = (fill0 == 8'd0) ? (rx_byte == BINARY_MARK) : bin0;
    wr    = fill0 < DEPTH_W;
    fill1 = wr ? fill0 + 8'd1 : fill0;

    fill_nxt = fill_r;
    bin_nxt  = bin_r;
    pend_nxt = pend_r;
    ovr_nxt  = ovr_r;
    sec_nxt  = sec_r;
    last_nxt = last_r;
    len_nxt  = len_r;

    mem_req         = '0;
    mem_req.wr_addr = fill0;
    mem_req.wr_data = rx_byte;
    mem_req.rd_addr = {1'b0, read_index};

    unique case (ucf_kind_t'(kind))
      KIND_BYTE: begin
        ovr_nxt       = ovr_r | pend_r;
        last_nxt      = sec_r;
        bin_nxt       = bin1;
        fill_nxt      = fill1;
        mem_req.wr_en = wr;
        // Mirror byte 1, the binary length, as it lands in the buffer.
        if (wr && (fill0 == 8'd1)) begin
          len_nxt = rx_byte;
        end
        if (bin1) begin
          if ((fill1 > 8'd1) && (fill1 == len_nxt)) begin
            pend_nxt = 1'b1;
          end
        end else if (rx_byte == NEWLINE_CHAR) begin
          pend_nxt = 1'b1;
        end
      end
      KIND_TICK: begin
        sec_nxt = sec_r + 32'd1;
      end
      KIND_RELEASE: begin
        pend_nxt = 1'b0;
        ovr_nxt  = 1'b0;
        fill_nxt = 8'd0;
      end
      KIND_READ: begin
        mem_req.rd_en = {1'b0, read_index} < DEPTH_W;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 8'd0;
      bin_r  <= 1'b0;
      pend_r <= 1'b0;
      ovr_r  <= 1'b0;
      sec_r  <= 32'd0;
      last_r <= 32'd0;
    end else if (step) begin
      fill_r <= fill_nxt;
      bin_r  <= bin_nxt;
      pend_r <= pend_nxt;
      ovr_r  <= ovr_nxt;
      sec_r  <= sec_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      len_r <= len_nxt;
    end
  end

  assign status.message_ready = pend_r;
  assign status.overrun       = ovr_r;
  assign status.binary_active = bin_r;
  assign status.fill_count    = fill_r;

  `UCF_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= DEPTH_W)
  `UCF_ASSERT_NEXT(a_release_clears, clk, rst_n, step && (kind == KIND_RELEASE), !pend_r && !ovr_r && (fill_r == 8'd0))
  `UCF_ASSERT_IMPL(a_overrun_cause, clk, rst_n, $rose(ovr_r), $past(pend_r))
  `UCF_ASSERT_NEXT(a_hold_idle, clk, rst_n, !step, $stable(fill_r) && $stable(sec_r) && $stable(pend_r))

endmodule

[rtl/core/uart_command_framer.sv]
// Top level of the serial command framer: input stage, framing control, buffer.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_ready   | kind, rx_byte, read_index
//  out_    | output    | out_valid / out_ready | flags, fill count, read data
//  cfg_    | input     | cfg_valid / cfg_ready | idle_timeout (16 bit)
//
// One word per cycle sustained while out_ready is high; words pass the input register.
// The input register feeds the framing logic, whose state registers and the buffer's
// registered read port form the result word.
// A stalled result holds the input stage; in_ready drops only when both are full.
// Reset (rst_n low, synchronous) clears flags, counts and idle_timeout to 1000;
// buffer contents are not cleared. cfg_ready is always high.
module uart_command_framer #(
  parameter int BUFFER_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_rx_byte,
  input  logic [6:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_message_ready,
  output logic        out_overrun,
  output logic        out_binary_active,
  output logic [7:0]  out_fill_count,
  output logic [7:0]  out_read_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import ucf_pkg::*;

`include "uart_command_framer_macros.svh"

  logic        s1_valid_r;
  logic [1:0]  s1_kind_r;
  logic [7:0]  s1_byte_r;
  logic [6:0]  s1_idx_r;
  logic        out_valid_r;
  logic [15:0] timeout_r;
  logic        advance;

  ucf_mem_req_t mem_req;
  ucf_status_t  status;

  // Advance the staged word whenever the result slot is free or being taken.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
      s1_idx_r  <= in_read_index;
    end
  end

  ucf_frame_ctrl #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .kind        (s1_kind_r),
    .rx_byte     (s1_byte_r),
    .read_index  (s1_idx_r),
    .idle_timeout(timeout_r),
    .mem_req     (mem_req),
    .status      (status)
  );

  ucf_frame_store #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_store (
    .clk    (clk),
    .step   (advance),
    .req    (mem_req),
    .rd_data(out_read_data)
  );

  assign out_valid         = out_valid_r;
  assign out_message_ready = status.message_ready;
  assign out_overrun       = status.overrun;
  assign out_binary_active = status.binary_active;
  assign out_fill_count    = status.fill_count;

  `UCF_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_r && !advance, s1_valid_r && $stable(s1_kind_r))
  `UCF_ASSERT_NEXT(a_advance_fills, clk, rst_n, advance, out_valid_r)
  `UCF_ASSERT_IMPL(a_stall_blocks, clk, rst_n, out_valid_r && !out_ready && s1_valid_r, !in_ready)

endmodule
